// ----- design/ulsu_pkg.sv -----
package ulsu_pkg;

   localparam int MEM_WORDS_DEFAULT = 4096;

   // Front-to-back queue
   localparam int QUEUE_DEPTH = 2;
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam logic [1:0] FUNC_LOAD  = 2'd1;
   localparam logic [1:0] FUNC_STORE = 2'd2;

   localparam logic [1:0] SIZE_BYTE = 2'd0;
   localparam logic [1:0] SIZE_HALF = 2'd1;
   localparam logic [1:0] SIZE_WORD = 2'd2;
   localparam logic [1:0] SIZE_BAD  = 2'd3;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_RANGE = 2'd1;
   localparam logic [1:0] ST_SIZE  = 2'd2;

   typedef enum logic [1:0] {
      OP_NONE,
      OP_LOAD,
      OP_STORE
   } op_type;

   typedef struct packed {
      logic [1:0]  func;
      logic [31:0] byte_address;
      logic [1:0]  access_size;
      logic        sign_extend_load;
      logic [31:0] store_value;
   } req_type;

   typedef struct packed {
      logic [31:0] load_value;
      logic [1:0]  status;
   } rsp_type;

   // Classified access; byte_en and wdata cover the two-word window
   typedef struct packed {
      op_type      op;
      logic [1:0]  status;
      logic [29:0] word_idx;
      logic [1:0]  byte_off;
      logic [1:0]  size;
      logic        sext;
      logic [7:0]  byte_en;
      logic [63:0] wdata;
   } back_op_type;

   typedef struct packed {
      logic              full;
      logic              empty;
      logic [QCNT_W-1:0] count;
   } q_stat_type;

   function automatic logic [3:0] lane_bytes(input logic [1:0] size);
      logic [3:0] lanes;
      case (size)
         SIZE_BYTE: lanes = 4'b0001;
         SIZE_HALF: lanes = 4'b0011;
         default:   lanes = 4'b1111;
      endcase
      return lanes;
   endfunction

endpackage

// ----- design/ulsu_front.sv -----
module ulsu_front #(
   parameter int MEM_WORDS = ulsu_pkg::MEM_WORDS_DEFAULT
) (
   input  ulsu_pkg::req_type     req_data,
   output ulsu_pkg::back_op_type op
);

   localparam logic [32:0] MEM_BYTES = 33'(MEM_WORDS) << 2;

   logic [32:0] addr_ext;
   logic [32:0] end_ext;
   logic [2:0]  nbytes;
   logic [63:0] sdata;
   logic        is_access;
   logic        start_bad;
   logic        end_bad;

   always_comb begin
      addr_ext = {1'b0, req_data.byte_address};
      case (req_data.access_size)
         ulsu_pkg::SIZE_BYTE: nbytes = 3'd1;
         ulsu_pkg::SIZE_HALF: nbytes = 3'd2;
         default:             nbytes = 3'd4;
      endcase
      end_ext   = addr_ext + 33'(nbytes);
      start_bad = addr_ext >= MEM_BYTES;
      end_bad   = end_ext > MEM_BYTES;

      case (req_data.access_size)
         ulsu_pkg::SIZE_BYTE: sdata = {56'd0, req_data.store_value[7:0]};
         ulsu_pkg::SIZE_HALF: sdata = {48'd0, req_data.store_value[15:0]};
         default:             sdata = {32'd0, req_data.store_value};
      endcase

      is_access = (req_data.func == ulsu_pkg::FUNC_LOAD) ||
                  (req_data.func == ulsu_pkg::FUNC_STORE);

      op.op       = ulsu_pkg::OP_NONE;
      op.status   = ulsu_pkg::ST_OK;
      op.word_idx = req_data.byte_address[31:2];
      op.byte_off = req_data.byte_address[1:0];
      op.size     = req_data.access_size;
      op.sext     = req_data.sign_extend_load;
      op.byte_en  = {4'd0, ulsu_pkg::lane_bytes(req_data.access_size)}
                    << req_data.byte_address[1:0];
      op.wdata    = sdata << {req_data.byte_address[1:0], 3'b000};

      // start range is checked before the size code
      if (is_access) begin
         if (start_bad) begin
            op.status = ulsu_pkg::ST_RANGE;
         end else if (req_data.access_size == ulsu_pkg::SIZE_BAD) begin
            op.status = ulsu_pkg::ST_SIZE;
         end else if (end_bad) begin
            op.status = ulsu_pkg::ST_RANGE;
         end else if (req_data.func == ulsu_pkg::FUNC_LOAD) begin
            op.op = ulsu_pkg::OP_LOAD;
         end else begin
            op.op = ulsu_pkg::OP_STORE;
         end
      end
   end

endmodule

// ----- design/ulsu_queue.sv -----
module ulsu_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  ulsu_pkg::back_op_type push_op,
   input  logic                  pop,
   output ulsu_pkg::back_op_type head_op,
   output ulsu_pkg::q_stat_type  stat
);

   localparam int PTR_W = (ulsu_pkg::QUEUE_DEPTH > 1) ? $clog2(ulsu_pkg::QUEUE_DEPTH) : 1;
   localparam logic [PTR_W-1:0] LAST = PTR_W'(ulsu_pkg::QUEUE_DEPTH - 1);
   localparam int QW = ulsu_pkg::QCNT_W;

   ulsu_pkg::back_op_type entries_ff [ulsu_pkg::QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QW-1:0]    count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      count_in = count_ff + QW'(push) - QW'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_op;
      end
   end

   assign head_op    = entries_ff[rd_ptr_ff];
   assign stat.full  = (count_ff == QW'(ulsu_pkg::QUEUE_DEPTH));
   assign stat.empty = (count_ff == '0);
   assign stat.count = count_ff;

endmodule

// ----- design/ulsu_back.sv -----
module ulsu_back #(
   parameter int MEM_WORDS = ulsu_pkg::MEM_WORDS_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  head_valid,
   input  ulsu_pkg::back_op_type head_op,
   output logic                  pop,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output ulsu_pkg::rsp_type     rsp_data
);

   // even words in one bank, odd words in the other: any access touches one row of each
   localparam int BANK_DEPTH = (MEM_WORDS + 1) / 2;
   localparam int BANK_AW    = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;

   logic [3:0][7:0] even_mem [BANK_DEPTH];
   logic [3:0][7:0] odd_mem  [BANK_DEPTH];
   logic [3:0][7:0] even_rd_ff;
   logic [3:0][7:0] odd_rd_ff;

   logic [30:0]        idx_ext;
   logic [30:0]        even_full;
   logic [30:0]        odd_full;
   logic [BANK_AW-1:0] even_row;
   logic [BANK_AW-1:0] odd_row;
   logic [3:0]         even_be;
   logic [3:0]         odd_be;
   logic [3:0][7:0]    even_wdata;
   logic [3:0][7:0]    odd_wdata;
   logic               swap;
   logic               wr_en;
   logic               rd_en;
   logic               adv_b;

   logic                 p_valid_ff, p_valid_in;
   ulsu_pkg::op_type     p_kind_ff;
   logic [1:0]           p_status_ff;
   logic                 p_swap_ff;
   logic [1:0]           p_off_ff;
   logic [1:0]           p_size_ff;
   logic                 p_sext_ff;

   logic                 rsp_valid_ff, rsp_valid_in;
   ulsu_pkg::rsp_type    rsp_data_ff, rsp_data_in;

   logic [63:0]          window;
   logic [63:0]          shifted;
   logic [31:0]          raw;
   logic [31:0]          ext;

   always_comb begin
      adv_b = p_valid_ff && (!rsp_valid_ff || !rsp_stall);
      pop   = head_valid && (!p_valid_ff || adv_b);

      idx_ext   = {1'b0, head_op.word_idx};
      even_full = (idx_ext + 31'd1) >> 1;
      odd_full  = idx_ext >> 1;
      even_row  = (even_full < 31'(BANK_DEPTH)) ? even_full[BANK_AW-1:0] : '0;
      odd_row   = (odd_full < 31'(BANK_DEPTH)) ? odd_full[BANK_AW-1:0] : '0;

      // odd start word: the low half of the window lives in the odd bank
      swap       = head_op.word_idx[0];
      even_be    = swap ? head_op.byte_en[7:4] : head_op.byte_en[3:0];
      odd_be     = swap ? head_op.byte_en[3:0] : head_op.byte_en[7:4];
      even_wdata = swap ? head_op.wdata[63:32] : head_op.wdata[31:0];
      odd_wdata  = swap ? head_op.wdata[31:0] : head_op.wdata[63:32];

      wr_en = pop && (head_op.op == ulsu_pkg::OP_STORE);
      rd_en = pop && (head_op.op == ulsu_pkg::OP_LOAD);
   end

   always_ff @(posedge clock) begin
      for (int l = 0; l < 4; l++) begin
         if (wr_en && even_be[l]) begin
            even_mem[even_row][l] <= even_wdata[l];
         end
         if (wr_en && odd_be[l]) begin
            odd_mem[odd_row][l] <= odd_wdata[l];
         end
      end
      if (rd_en) begin
         even_rd_ff <= even_mem[even_row];
         odd_rd_ff  <= odd_mem[odd_row];
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         p_kind_ff   <= head_op.op;
         p_status_ff <= head_op.status;
         p_swap_ff   <= swap;
         p_off_ff    <= head_op.byte_off;
         p_size_ff   <= head_op.size;
         p_sext_ff   <= head_op.sext;
      end
   end

   // align and extend the load data
   always_comb begin
      window  = p_swap_ff ? {even_rd_ff, odd_rd_ff} : {odd_rd_ff, even_rd_ff};
      shifted = window >> {p_off_ff, 3'b000};
      raw     = shifted[31:0];
      case (p_size_ff)
         ulsu_pkg::SIZE_BYTE: ext = {{24{p_sext_ff & raw[7]}}, raw[7:0]};
         ulsu_pkg::SIZE_HALF: ext = {{16{p_sext_ff & raw[15]}}, raw[15:0]};
         default:             ext = raw;
      endcase

      p_valid_in = pop ? 1'b1 : (adv_b ? 1'b0 : p_valid_ff);

      if (adv_b) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end

      rsp_data_in = rsp_data_ff;
      if (adv_b) begin
         rsp_data_in.load_value = (p_kind_ff == ulsu_pkg::OP_LOAD) ? ext : 32'd0;
         rsp_data_in.status     = p_status_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         p_valid_ff   <= p_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ----- design/unaligned_load_store_unit_core.sv -----
// Unaligned load/store unit over a little-endian word memory of MEM_WORDS words.
// req channel: one access per transaction (idle, load or store of a byte,
//   half word or word at any byte address). Accepted at a clock edge with
//   req_valid high and req_stall low. req_stall is high while the two-entry
//   queue between the classify front and the memory back end is full.
// rsp channel: exactly one rsp transaction per req transaction, in order,
//   carrying the extended load value (zero for stores, idle and errors) and
//   a status. Out-of-range addresses and bad size codes change nothing.
// Path: an accepted transaction goes through the queue, then the memory read,
//   then the align/extend step into the output register before it shows on
//   rsp_valid. Throughput: one transaction per cycle while rsp_stall is low; the
//   memory is split into even and odd word banks with byte write enables, so
//   a crossing access reads or writes both of its words in the same cycle.
// When rsp_stall is high the output register holds; one more transaction
//   waits in the read stage and two in the queue before req_stall rises.
// Reset (synchronous, active high) empties the queue and pipeline; memory
//   contents are not cleared and read back undefined until stored.
module unaligned_load_store_unit_core #(
   parameter int MEM_WORDS = ulsu_pkg::MEM_WORDS_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  ulsu_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output ulsu_pkg::rsp_type rsp_data
);

   ulsu_pkg::back_op_type front_op;
   ulsu_pkg::back_op_type head_op;
   ulsu_pkg::q_stat_type  q_stat;
   logic                  push;
   logic                  pop;

   ulsu_front #(
      .MEM_WORDS(MEM_WORDS)
   ) u_front (
      .req_data(req_data),
      .op      (front_op)
   );

   assign req_stall = q_stat.full;
   assign push      = req_valid && !q_stat.full;

   ulsu_queue u_queue (
      .clock  (clock),
      .reset  (reset),
      .push   (push),
      .push_op(front_op),
      .pop    (pop),
      .head_op(head_op),
      .stat   (q_stat)
   );

   ulsu_back #(
      .MEM_WORDS(MEM_WORDS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .head_valid(!q_stat.empty),
      .head_op   (head_op),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

`ifndef SYNTHESIS
   a_err_zero_value: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.status != ulsu_pkg::ST_OK) |-> rsp_data.load_value == 32'd0)
      else $error("error response carries nonzero load value");

   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      pop |-> !q_stat.empty)
      else $error("back end issued from an empty queue");

   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      int'(q_stat.count) <= ulsu_pkg::QUEUE_DEPTH)
      else $error("queue count exceeds depth");

   a_full_push_pop: assert property (@(posedge clock) disable iff (reset)
      q_stat.full && !pop |=> q_stat.full)
      else $error("queue drained without a pop");
`endif

endmodule
